/* hw/rtl/fckv_pkg.sv */
// Shared constants for the key/value table: default sizes, fixed field widths
// and command codes.
// No dependencies.
package fckv_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int CMD_W = 3;
    localparam int POS_W = 4;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_UPD  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ERASE    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd4;
    localparam logic [CMD_W-1:0] CMD_GET_KEY  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_GET_IDX  = 3'd6;
    localparam logic [CMD_W-1:0] CMD_NOP      = 3'd7;

endpackage

/* hw/rtl/fixed_capacity_key_value_table_unit.sv */
// Top level of the key/value table: sequencer, slot memories, one shared key
// comparator and the result register.
// Depends on fckv_pkg.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+------------------------------------------
//  in       | i_in_valid / o_in_stall      | i_command, i_key, i_value, i_position
//  out      | o_out_valid / i_out_stall    | o_ok, o_found_key, o_found_value, o_count
//  cfg      | i_cfg_valid / o_cfg_ready    | i_cfg_data (capacity)
//
// Every keyed command scans the live slots, one slot a cycle through the single
// memory read port into the shared key comparator; get_by_index reads only its
// slot, skipping the read when the position is at or past the count, and a no-op goes
// straight to the final step. Erase then moves the later pairs down one slot
// over the same port.
// Reset (synchronous, active low) clears the count, the sequencer and the result
// valid and sets capacity to 16; slot memories are not cleared, so no clearing
// pass is needed. A stalled result holds in the output register while the next
// item is taken and worked; only the final step waits for that register.
module fixed_capacity_key_value_table_unit #(
    parameter int DEPTH      = fckv_pkg::DEPTH_DEF,
    parameter int KEY_BITS   = fckv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = fckv_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [fckv_pkg::CMD_W-1:0]    i_command,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic [VALUE_BITS-1:0]         i_value,
    input  logic [fckv_pkg::POS_W-1:0]    i_position,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_ok,
    output logic [KEY_BITS-1:0]           o_found_key,
    output logic [VALUE_BITS-1:0]         o_found_value,
    output logic [$clog2(DEPTH+1)-1:0]    o_count,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fckv_pkg::CAP_W-1:0]    i_cfg_data
);
    import fckv_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int PW    = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_SCAN    = 7'b0000010,
        ST_RESOLVE = 7'b0000100,
        ST_SHIFT   = 7'b0001000,
        ST_FETCH   = 7'b0010000,
        ST_GRAB    = 7'b0100000,
        ST_DONE    = 7'b1000000
    } t_state;

    t_state                r_state;

    // latched item
    logic [CMD_W-1:0]      r_cmd;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [IDX_W-1:0]      r_pos_addr;

    // table state
    logic [CNT_W-1:0]      r_count;
    logic [CAP_W-1:0]      r_cap;

    // scan / shift bookkeeping
    logic [CNT_W-1:0]      r_idx;
    logic                  r_chk;
    logic [IDX_W-1:0]      r_chk_idx;
    logic                  r_chk_last;
    logic                  r_hit;
    logic [IDX_W-1:0]      r_slot;
    logic [VALUE_BITS-1:0] r_fval;
    logic                  r_mv;
    logic [IDX_W-1:0]      r_mv_dst;

    // pending result
    logic                  r_ok;
    logic [KEY_BITS-1:0]   r_rkey;
    logic [VALUE_BITS-1:0] r_rval;

    // output register
    logic                  r_out_valid;
    logic                  r_out_ok;
    logic [KEY_BITS-1:0]   r_out_key;
    logic [VALUE_BITS-1:0] r_out_val;
    logic [CNT_W-1:0]      r_out_count;

    // slot memories
    logic [KEY_BITS-1:0]   r_key_mem [DEPTH];
    logic [VALUE_BITS-1:0] r_val_mem [DEPTH];
    logic [KEY_BITS-1:0]   r_key_q;
    logic [VALUE_BITS-1:0] r_val_q;

    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      wr_addr;
    logic                  wr_key_en;
    logic                  wr_val_en;
    logic [KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0] wr_val;

    logic                  in_accept;
    logic                  out_load;
    logic                  key_match;
    logic                  issue;
    logic [CNT_W-1:0]      n_idx_inc;
    logic [CNT_W-1:0]      idx_dec;
    logic [LW-1:0]         cap_ext;
    logic [LW-1:0]         limit;
    logic                  room;
    logic [PW-1:0]         pos_ext;
    logic                  pos_ok;
    logic                  do_insert;
    logic                  do_update;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // Shared comparator: one stored key against the item key per cycle.
    assign key_match = (r_key_q == r_key);

    assign issue     = (r_idx < r_count);
    assign n_idx_inc = r_idx + CNT_W'(1);
    assign idx_dec   = r_idx - CNT_W'(1);

    // Effective limit saturates capacity at the slot count.
    assign cap_ext = LW'(r_cap);
    assign limit   = (cap_ext > LW'(DEPTH)) ? LW'(DEPTH) : cap_ext;
    assign room    = (LW'(r_count) < limit);

    assign pos_ext = PW'(i_position);
    assign pos_ok  = (pos_ext < PW'(r_count));

    assign do_update = r_hit && ((r_cmd == CMD_UPDATE) || (r_cmd == CMD_INS_UPD));
    assign do_insert = !r_hit && room && ((r_cmd == CMD_INSERT) || (r_cmd == CMD_INS_UPD));

    assign rd_addr = (r_state == ST_FETCH) ? r_pos_addr : r_idx[IDX_W-1:0];

    // Single write port: move-down during erase, append or value update at resolve.
    always_comb begin
        wr_key_en = 1'b0;
        wr_val_en = 1'b0;
        wr_addr   = r_slot;
        wr_key    = r_key;
        wr_val    = r_val;
        if (r_state == ST_SHIFT && r_mv) begin
            wr_key_en = 1'b1;
            wr_val_en = 1'b1;
            wr_addr   = r_mv_dst;
            wr_key    = r_key_q;
            wr_val    = r_val_q;
        end else if (r_state == ST_RESOLVE && do_insert) begin
            wr_key_en = 1'b1;
            wr_val_en = 1'b1;
            wr_addr   = r_count[IDX_W-1:0];
        end else if (r_state == ST_RESOLVE && do_update) begin
            wr_val_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_key_en) r_key_mem[wr_addr] <= wr_key;
        if (wr_val_en) r_val_mem[wr_addr] <= wr_val;
        r_key_q <= r_key_mem[rd_addr];
        r_val_q <= r_val_mem[rd_addr];
    end

    // Capacity register; user must make writes arrive only while idle; not enforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_chk   <= 1'b0;
            r_mv    <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_cmd      <= i_command;
                        r_key      <= i_key;
                        r_val      <= i_value;
                        r_pos_addr <= IDX_W'(pos_ext);
                        r_ok       <= 1'b0;
                        r_rkey     <= i_key;
                        r_rval     <= '0;
                        r_hit      <= 1'b0;
                        r_chk      <= 1'b0;
                        r_idx      <= '0;
                        if (i_command == CMD_GET_IDX) begin
                            r_state <= pos_ok ? ST_FETCH : ST_DONE;
                        end else if (i_command == CMD_NOP) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= (r_count == '0) ? ST_RESOLVE : ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    // issue one read a cycle, compare the one returned last cycle
                    if (r_chk && key_match) begin
                        r_hit   <= 1'b1;
                        r_slot  <= r_chk_idx;
                        r_fval  <= r_val_q;
                        r_state <= ST_RESOLVE;
                    end else if (r_chk && r_chk_last) begin
                        r_state <= ST_RESOLVE;
                    end else begin
                        r_chk      <= issue;
                        r_chk_idx  <= r_idx[IDX_W-1:0];
                        r_chk_last <= (n_idx_inc == r_count);
                        if (issue) r_idx <= n_idx_inc;
                    end
                end
                ST_RESOLVE: begin
                    unique case (r_cmd) inside
                        CMD_INSERT, CMD_UPDATE, CMD_INS_UPD: begin
                            r_ok <= do_insert || do_update;
                            if (do_insert) r_count <= r_count + CNT_W'(1);
                            r_state <= ST_DONE;
                        end
                        CMD_ERASE: begin
                            if (r_hit) begin
                                r_idx   <= CNT_W'(r_slot) + CNT_W'(1);
                                r_mv    <= 1'b0;
                                r_state <= ST_SHIFT;
                            end else begin
                                r_state <= ST_DONE;
                            end
                        end
                        CMD_CONTAINS, CMD_GET_KEY: begin
                            r_ok    <= r_hit;
                            r_rval  <= r_hit ? r_fval : '0;
                            r_state <= ST_DONE;
                        end
                        default: begin
                            r_state <= ST_DONE;
                        end
                    endcase
                end
                ST_SHIFT: begin
                    // read slot r_idx, write it one slot down on the next cycle
                    if (issue) begin
                        r_mv     <= 1'b1;
                        r_mv_dst <= idx_dec[IDX_W-1:0];
                        r_idx    <= n_idx_inc;
                    end else begin
                        r_mv <= 1'b0;
                        if (!r_mv) begin
                            r_count <= r_count - CNT_W'(1);
                            r_ok    <= 1'b1;
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_FETCH: begin
                    r_state <= ST_GRAB;
                end
                ST_GRAB: begin
                    r_ok    <= 1'b1;
                    r_rkey  <= r_key_q;
                    r_rval  <= r_val_q;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_load) r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Output register: hold while stalled, load when free or being taken.
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ok    <= r_ok;
            r_out_key   <= r_rkey;
            r_out_val   <= r_rval;
            r_out_count <= r_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_out_ok;
    assign o_found_key   = r_out_key;
    assign o_found_value = r_out_val;
    assign o_count       = r_out_count;

    // An accepted item keeps the sequencer busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != ST_IDLE))
        else $error("sequencer idle right after accepting an item");

    // A new result appears only out of the final step.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result loaded outside the final step");

    // The count holds while no item is in work.
    a_count_stable_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |=> $stable(r_count))
        else $error("count changed while idle");

    // An append never pushes the count past the slot count.
    a_append_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESOLVE && do_insert) |-> (r_count < CNT_W'(DEPTH)))
        else $error("append beyond the last slot");

endmodule

/* sim/tb_fixed_capacity_key_value_table_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for fixed_capacity_key_value_table_unit: a directed
// table, then random command streams over several capacity settings.
// Depends on fckv_pkg and the unit's RTL.
module tb_fixed_capacity_key_value_table_unit;

    import fckv_pkg::*;

    localparam int SLOTS        = DEPTH_DEF;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 130;
    localparam int DRAIN_CYCLES = 48;      // a keyed erase over a full table plus margin
    localparam int CYCLE_LIMIT  = 400000;  // ends a run that hangs

    // One result item as the unit presents it.
    typedef struct packed {
        logic                 ok;
        logic [31:0]          key;
        logic [31:0]          value;
        logic [CAP_W-1:0]     count;
    } reply_t;

    // One row of the directed table; typed rows carry their result inline.
    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [31:0]          key;
        logic [31:0]          value;
        logic [POS_W-1:0]     pos;
        logic                 typed;
        reply_t               want;
    } step_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [CMD_W-1:0]   i_command = CMD_INSERT;
    logic [31:0]        i_key = '0;
    logic [31:0]        i_value = '0;
    logic [POS_W-1:0]   i_position = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_ok;
    logic [31:0]        o_found_key;
    logic [31:0]        o_found_value;
    logic [CAP_W-1:0]   o_count;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CAP_W-1:0]   i_cfg_data = '0;

    // Shadow of the table: live pairs packed from slot 0, count and capacity.
    logic [31:0]        shadow_keys [SLOTS];
    logic [31:0]        shadow_vals [SLOTS];
    int                 shadow_count = 0;
    logic [CAP_W-1:0]   shadow_cap = CAP_RESET;

    reply_t             pending_replies [$];
    step_row_t          directed_rows [$];
    logic [31:0]        key_pool [24];
    logic [CAP_W-1:0]   cap_plan [PHASES];
    bit                 jitter_on = 1'b1;
    int                 mismatches = 0;
    int                 cycle_count = 0;
    int                 stall_left = 0;

    fixed_capacity_key_value_table_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_ok          (o_ok),
        .o_found_key   (o_found_key),
        .o_found_value (o_found_value),
        .o_count       (o_count),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // 8 ns clock: low half, then high half.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Bound the run; a hung handshake ends here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL fixed_capacity_key_value_table_unit");
            $finish;
        end
    end

    // Apply one command to the shadow table and return the result it yields.
    // Searches cover live slots only; erase moves later pairs down one slot.
    function automatic reply_t apply_command(input logic [CMD_W-1:0] cmd,
                                             input logic [31:0] key,
                                             input logic [31:0] value,
                                             input logic [POS_W-1:0] pos);
        reply_t r;
        int     slot;
        int     room;
        int     j;
        r.ok    = 1'b0;
        r.key   = key;
        r.value = '0;
        slot    = -1;
        for (j = 0; j < shadow_count; j++)
            if (slot < 0 && shadow_keys[j] == key)
                slot = j;
        // Capacity above the slot count saturates.
        room = (shadow_cap > SLOTS) ? SLOTS : int'(shadow_cap);
        case (cmd)
            CMD_INSERT, CMD_INS_UPD: begin
                if (slot >= 0 && cmd == CMD_INS_UPD) begin
                    shadow_vals[slot] = value;
                    r.ok = 1'b1;
                end else if (slot < 0 && shadow_count < room) begin
                    shadow_keys[shadow_count] = key;
                    shadow_vals[shadow_count] = value;
                    shadow_count++;
                    r.ok = 1'b1;
                end
            end
            CMD_UPDATE: begin
                if (slot >= 0) begin
                    shadow_vals[slot] = value;
                    r.ok = 1'b1;
                end
            end
            CMD_ERASE: begin
                if (slot >= 0) begin
                    for (j = slot; j < shadow_count - 1; j++) begin
                        shadow_keys[j] = shadow_keys[j + 1];
                        shadow_vals[j] = shadow_vals[j + 1];
                    end
                    shadow_count--;
                    r.ok = 1'b1;
                end
            end
            CMD_CONTAINS, CMD_GET_KEY: begin
                if (slot >= 0) begin
                    r.value = shadow_vals[slot];
                    r.ok = 1'b1;
                end
            end
            CMD_GET_IDX: begin
                if (int'(pos) < shadow_count) begin
                    r.key   = shadow_keys[pos];
                    r.value = shadow_vals[pos];
                    r.ok    = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.count = CAP_W'(shadow_count);
        return r;
    endfunction

    // Offer one item, optionally after an idle burst; hold it until accepted,
    // then record the result it must produce.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [31:0] key,
                             input logic [31:0] value, input logic [POS_W-1:0] pos,
                             input logic typed, input reply_t typed_reply);
        int     gap;
        reply_t want;
        @(negedge i_clk);
        if (jitter_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_key      <= key;
        i_value    <= value;
        i_position <= pos;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        want = apply_command(cmd, key, value, pos);
        if (typed)
            want = typed_reply;
        pending_replies.push_back(want);
    endtask

    // Drop valid, wait out every pending result and the tail of the last item.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write the capacity register; call only while the unit is idle.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_cap = cap;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [31:0] key,
                           input logic [31:0] value, input logic [POS_W-1:0] pos,
                           input logic typed, input logic ok, input logic [31:0] rkey,
                           input logic [31:0] rvalue, input logic [CAP_W-1:0] rcount);
        step_row_t row;
        row.cmd        = cmd;
        row.key        = key;
        row.value      = value;
        row.pos        = pos;
        row.typed      = typed;
        row.want.ok    = ok;
        row.want.key   = rkey;
        row.want.value = rvalue;
        row.want.count = rcount;
        directed_rows.push_back(row);
    endtask

    // Pick a key: half the time a live one so hits are common, then a small pool so
    // inserts collide, and now and then any 32-bit key.
    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5 && shadow_count > 0)
            return shadow_keys[$urandom_range(0, shadow_count - 1)];
        else if (r < 9)
            return key_pool[$urandom_range(0, 23)];
        return $urandom;
    endfunction

    task automatic send_random_item();
        int               r;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        r = $urandom_range(0, 99);
        if (r < 24)      cmd = CMD_INSERT;
        else if (r < 34) cmd = CMD_UPDATE;
        else if (r < 48) cmd = CMD_INS_UPD;
        else if (r < 64) cmd = CMD_ERASE;
        else if (r < 74) cmd = CMD_CONTAINS;
        else if (r < 84) cmd = CMD_GET_KEY;
        else if (r < 96) cmd = CMD_GET_IDX;
        else             cmd = CMD_NOP;
        // Half the reads land on or just past the live range.
        if ($urandom_range(0, 1) == 0)
            pos = POS_W'($urandom_range(0, SLOTS - 1));
        else
            pos = (shadow_count < SLOTS) ? POS_W'($urandom_range(0, shadow_count))
                                         : POS_W'($urandom_range(0, SLOTS - 1));
        send_item(cmd, pick_key(), $urandom, pos, 1'b0, '0);
    endtask

    // Random stall bursts on the result side.
    always @(negedge i_clk) begin
        if (!i_rst_n || !jitter_on) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if ($urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare each accepted result with the oldest pending one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin : check_result
            reply_t want;
            if (pending_replies.size() == 0) begin
                $display("%0t: result with none pending, expected nothing, actual ok %0d key 0x%0h",
                         $time, o_ok, o_found_key);
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                report_field("ok", 32'(want.ok), 32'(o_ok));
                report_field("found_key", want.key, o_found_key);
                report_field("found_value", want.value, o_found_value);
                report_field("count", 32'(want.count), 32'(o_count));
            end
        end
    end

    initial begin
        // Empty table: every lookup misses and echoes its key.
        add_row(CMD_GET_IDX,  32'hFFFF_FFFF, 32'h0, 4'd0, 1, 0, 32'hFFFF_FFFF, 0, 0);
        add_row(CMD_CONTAINS, 32'h0, 32'h0, 4'd0, 1, 0, 32'h0, 0, 0);
        add_row(CMD_UPDATE,   32'h5, 32'h7, 4'd0, 1, 0, 32'h5, 0, 0);
        add_row(CMD_ERASE,    32'h5, 32'h0, 4'd0, 1, 0, 32'h5, 0, 0);
        add_row(CMD_GET_KEY,  32'h9, 32'h0, 4'd0, 1, 0, 32'h9, 0, 0);
        // Extreme keys and values, then a duplicate insert.
        add_row(CMD_INSERT,   32'h0, 32'hFFFF_FFFF, 4'd0, 1, 1, 32'h0, 0, 1);
        add_row(CMD_INSERT,   32'hFFFF_FFFF, 32'h0, 4'd0, 1, 1, 32'hFFFF_FFFF, 0, 2);
        add_row(CMD_INSERT,   32'h0, 32'h1, 4'd0, 1, 0, 32'h0, 0, 2);
        add_row(CMD_GET_KEY,  32'h0, 32'h0, 4'd0, 1, 1, 32'h0, 32'hFFFF_FFFF, 2);
        add_row(CMD_GET_IDX,  32'h1234, 32'h0, 4'd1, 1, 1, 32'hFFFF_FFFF, 0, 2);
        add_row(CMD_UPDATE,   32'h0, 32'h1234_5678, 4'd0, 1, 1, 32'h0, 0, 2);
        // Insert-or-update on a present key, then on a new one.
        add_row(CMD_INS_UPD,  32'h0, 32'hA5A5_A5A5, 4'd0, 1, 1, 32'h0, 0, 2);
        add_row(CMD_INS_UPD,  32'h8000_0000, 32'h1, 4'd0, 1, 1, 32'h8000_0000, 0, 3);
        add_row(CMD_CONTAINS, 32'h8000_0000, 32'h0, 4'd0, 1, 1, 32'h8000_0000, 1, 3);
        // Positions past the live range, and the no-op command.
        add_row(CMD_GET_IDX,  32'h55AA, 32'h0, 4'd15, 1, 0, 32'h55AA, 0, 3);
        add_row(CMD_GET_IDX,  32'h0, 32'h0, 4'd3, 1, 0, 32'h0, 0, 3);
        add_row(CMD_NOP,      32'hDEAD_BEEF, 32'h1, 4'd0, 1, 0, 32'hDEAD_BEEF, 0, 3);
        // Erase slot 0 and check the move-down, then erase the last slot.
        add_row(CMD_ERASE,    32'h0, 32'h0, 4'd0, 1, 1, 32'h0, 0, 2);
        add_row(CMD_GET_IDX,  32'h0, 32'h0, 4'd0, 0, 0, 0, 0, 0);
        add_row(CMD_GET_IDX,  32'h0, 32'h0, 4'd1, 0, 0, 0, 0, 0);
        add_row(CMD_GET_KEY,  32'h0, 32'h0, 4'd0, 1, 0, 32'h0, 0, 2);
        add_row(CMD_ERASE,    32'h8000_0000, 32'h0, 4'd0, 1, 1, 32'h8000_0000, 0, 1);
        add_row(CMD_GET_IDX,  32'h0, 32'h0, 4'd0, 0, 0, 0, 0, 0);

        // Saturating top value first, then below the count of a full table,
        // zero, one, the nominal limit, a random one, a middle one, and the
        // nominal limit again for the calm closing phase.
        cap_plan[0] = 5'd31;
        cap_plan[1] = 5'd3;
        cap_plan[2] = 5'd0;
        cap_plan[3] = 5'd1;
        cap_plan[4] = 5'd16;
        cap_plan[5] = CAP_W'($urandom_range(0, 31));
        cap_plan[6] = 5'd8;
        cap_plan[7] = 5'd16;

        // Hold reset low from the start, then release it once.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_capacity(CAP_RESET);
        foreach (directed_rows[n])
            send_item(directed_rows[n].cmd, directed_rows[n].key, directed_rows[n].value,
                      directed_rows[n].pos, directed_rows[n].typed, directed_rows[n].want);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            set_capacity(cap_plan[phase]);
            // Keep the closing phase free of gaps and stalls.
            if (phase == PHASES - 1)
                jitter_on = 1'b0;
            foreach (key_pool[n])
                key_pool[n] = $urandom;
            // Fill the table past its limit before the first random items.
            if (phase == 0)
                for (int n = 0; n < SLOTS + 2; n++)
                    send_item(CMD_INSERT, $urandom, $urandom, '0, 1'b0, '0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_item();
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("PASS fixed_capacity_key_value_table_unit");
        end else begin
            $display("FAIL fixed_capacity_key_value_table_unit");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/fckv_pkg.sv
hw/rtl/fixed_capacity_key_value_table_unit.sv
sim/tb_fixed_capacity_key_value_table_unit.sv
